[sv/three_stage_fall_detector_core_macros.svh]
// Assertion helpers for the fall detector. They assume clk and rst in scope.
`ifndef THREE_STAGE_FALL_DETECTOR_CORE_MACROS_SVH
`define THREE_STAGE_FALL_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define FDET_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("fdet check failed");

`define FDET_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fdet check failed");

`define FDET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fdet check failed");

`else

`define FDET_ASSERT(lbl, expr)
`define FDET_ASSERT_IMP(lbl, ante, cons)
`define FDET_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[sv/fdet_pkg.sv]
`default_nettype none

package fdet_pkg;

  localparam int ACCEL_FRAC_BITS = 12;
  localparam int SAMPLE_WIDTH    = 16;

  // squared-magnitude widths
  localparam int SQ_W     = 2 * SAMPLE_WIDTH - 1;
  localparam int SUM_W    = 2 * SAMPLE_WIDTH;
  localparam int S100_W   = SUM_W + 7;
  localparam int LIM_SQ_W = 17;
  localparam int LTHR_W   = LIM_SQ_W + 2 * ACCEL_FRAC_BITS;
  localparam int CMP_W    = (S100_W > LTHR_W) ? S100_W : LTHR_W;
  localparam int GSQ_W    = 32;
  localparam int GCMP_W   = (SUM_W > GSQ_W) ? SUM_W : GSQ_W;

  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int OQDEPTH = 2;
  localparam int OQPTR_W = $clog2(OQDEPTH);
  localparam int OQCNT_W = $clog2(OQDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_G_LIMIT  = 3'd0,
    REG_HIGH_G_LIMIT = 3'd1,
    REG_ROTATION_MIN = 3'd2,
    REG_ROTATION_MAX = 3'd3,
    REG_STILL_LIMIT  = 3'd4,
    REG_ARM_WINDOW   = 3'd5,
    REG_SETTLE_WAIT  = 3'd6
  } fdet_reg_t;

  localparam logic [7:0]  LOW_G_RESET   = 8'd2;
  localparam logic [7:0]  HIGH_G_RESET  = 8'd12;
  localparam logic [15:0] ROT_MIN_RESET = 16'd30;
  localparam logic [15:0] ROT_MAX_RESET = 16'd400;
  localparam logic [15:0] STILL_RESET   = 16'd10;
  localparam logic [7:0]  ARM_WIN_RESET = 8'd6;
  localparam logic [7:0]  SETTLE_RESET  = 8'd10;

  // thresholds handed from the register file to the front end
  typedef struct packed {
    logic [CMP_W-1:0]  lo_thr;
    logic [CMP_W-1:0]  hi_thr;
    logic [GSQ_W-1:0]  rot_min_sq;
    logic [GSQ_W-1:0]  rot_max_sq;
    logic [GSQ_W-1:0]  still_sq;
  } fdet_thr_t;

  typedef struct packed {
    logic [CNT_W-1:0] arm_window;
    logic [CNT_W-1:0] settle_wait;
  } fdet_timing_t;

  // one classified sample, as queued between front and back
  typedef struct packed {
    logic am_low;
    logic am_high;
    logic in_band;
    logic still_ok;
  } fdet_flags_t;

endpackage

`default_nettype wire

[sv/fdet_cfg.sv]
`default_nettype none

module fdet_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [fdet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [fdet_pkg::CFG_DATA_W-1:0] cfg_data,
  output fdet_pkg::fdet_thr_t                  thr,
  output fdet_pkg::fdet_timing_t               timing
);

  logic [7:0]  low_g_limit;
  logic [7:0]  high_g_limit;
  logic [15:0] rotation_min;
  logic [15:0] rotation_max;
  logic [15:0] still_limit;
  logic [7:0]  arm_window;
  logic [7:0]  settle_wait;

  logic [8:0]                      lo1;
  logic [fdet_pkg::LIM_SQ_W-1:0]   lo_sq;
  logic [15:0]                     hi_sq;
  fdet_pkg::fdet_thr_t             thr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_g_limit  <= fdet_pkg::LOW_G_RESET;
      high_g_limit <= fdet_pkg::HIGH_G_RESET;
      rotation_min <= fdet_pkg::ROT_MIN_RESET;
      rotation_max <= fdet_pkg::ROT_MAX_RESET;
      still_limit  <= fdet_pkg::STILL_RESET;
      arm_window   <= fdet_pkg::ARM_WIN_RESET;
      settle_wait  <= fdet_pkg::SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fdet_pkg::REG_LOW_G_LIMIT:  low_g_limit  <= cfg_data[7:0];
        fdet_pkg::REG_HIGH_G_LIMIT: high_g_limit <= cfg_data[7:0];
        fdet_pkg::REG_ROTATION_MIN: rotation_min <= cfg_data;
        fdet_pkg::REG_ROTATION_MAX: rotation_max <= cfg_data;
        fdet_pkg::REG_STILL_LIMIT:  still_limit  <= cfg_data;
        fdet_pkg::REG_ARM_WINDOW:   arm_window   <= cfg_data[7:0];
        fdet_pkg::REG_SETTLE_WAIT:  settle_wait  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // squared limits, registered; they settle in the cycle after a write
  always_comb begin
    lo1   = {1'b0, low_g_limit} + 9'd1;
    lo_sq = lo1 * lo1;
    hi_sq = high_g_limit * high_g_limit;
    thr_next.lo_thr = fdet_pkg::CMP_W'(lo_sq) << (2 * fdet_pkg::ACCEL_FRAC_BITS);
    thr_next.hi_thr = fdet_pkg::CMP_W'(hi_sq) << (2 * fdet_pkg::ACCEL_FRAC_BITS);
    thr_next.rot_min_sq = rotation_min * rotation_min;
    thr_next.rot_max_sq = rotation_max * rotation_max;
    thr_next.still_sq   = still_limit * still_limit;
  end

  always_ff @(posedge clk) begin
    thr <= thr_next;
  end

  assign timing = {arm_window, settle_wait};

endmodule

`default_nettype wire

[sv/fdet_front.sv]
`default_nettype none

module fdet_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] accel_x,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] accel_y,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] accel_z,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] gyro_x,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] gyro_y,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] gyro_z,
  input  wire fdet_pkg::fdet_thr_t                  thr,
  output logic                                      q_push,
  output fdet_pkg::fdet_flags_t                     q_data,
  input  wire logic                                 q_full
);

  localparam int W = fdet_pkg::SAMPLE_WIDTH;

  function automatic logic [fdet_pkg::SQ_W-1:0] sq_of(input logic [W-1:0] v);
    logic [W-1:0]   m;
    logic [2*W-1:0] p;
    m = v[W-1] ? (~v + 1'b1) : v;
    p = m * m;
    return p[fdet_pkg::SQ_W-1:0];
  endfunction

  logic                       s1_valid;
  logic                       s1_valid_next;
  logic [fdet_pkg::SQ_W-1:0]  a_sq [3];
  logic [fdet_pkg::SQ_W-1:0]  g_sq [3];
  logic                       load;

  logic [fdet_pkg::SUM_W-1:0]  s_sum;
  logic [fdet_pkg::SUM_W-1:0]  g_sum;
  logic [fdet_pkg::CMP_W-1:0]  s_ext;
  logic [fdet_pkg::CMP_W-1:0]  s100;
  logic [fdet_pkg::GCMP_W-1:0] g_ext;

  assign full   = s1_valid && q_full;
  assign load   = push && !full;
  assign q_push = s1_valid && !q_full;

  always_comb begin
    s1_valid_next = s1_valid;
    if (load) begin
      s1_valid_next = 1'b1;
    end else if (q_push) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  // stage 1: squares of each axis
  always_ff @(posedge clk) begin
    if (load) begin
      a_sq[0] <= sq_of(accel_x);
      a_sq[1] <= sq_of(accel_y);
      a_sq[2] <= sq_of(accel_z);
      g_sq[0] <= sq_of(gyro_x);
      g_sq[1] <= sq_of(gyro_y);
      g_sq[2] <= sq_of(gyro_z);
    end
  end

  // stage 2: sums and threshold compares; 100*S as 64S + 32S + 4S
  always_comb begin
    s_sum = fdet_pkg::SUM_W'(a_sq[0]) + fdet_pkg::SUM_W'(a_sq[1])
          + fdet_pkg::SUM_W'(a_sq[2]);
    g_sum = fdet_pkg::SUM_W'(g_sq[0]) + fdet_pkg::SUM_W'(g_sq[1])
          + fdet_pkg::SUM_W'(g_sq[2]);
    s_ext = fdet_pkg::CMP_W'(s_sum);
    s100  = (s_ext << 6) + (s_ext << 5) + (s_ext << 2);
    g_ext = fdet_pkg::GCMP_W'(g_sum);
    q_data.am_low   = s100 < thr.lo_thr;
    q_data.am_high  = s100 >= thr.hi_thr;
    q_data.in_band  = (g_ext >= fdet_pkg::GCMP_W'(thr.rot_min_sq))
                   && (g_ext <= fdet_pkg::GCMP_W'(thr.rot_max_sq));
    q_data.still_ok = g_ext <= fdet_pkg::GCMP_W'(thr.still_sq);
  end

endmodule

`default_nettype wire

[sv/fdet_queue.sv]
`default_nettype none

module fdet_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire fdet_pkg::fdet_flags_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       empty,
  output fdet_pkg::fdet_flags_t      head
);

  fdet_pkg::fdet_flags_t             mem [fdet_pkg::QDEPTH];
  logic [fdet_pkg::QPTR_W-1:0]       wr_ptr;
  logic [fdet_pkg::QPTR_W-1:0]       rd_ptr;
  logic [fdet_pkg::QCNT_W-1:0]       cnt;
  logic                              do_push;
  logic                              do_pop;

  assign full    = cnt == fdet_pkg::QCNT_W'(fdet_pkg::QDEPTH);
  assign empty   = cnt == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/fdet_back.sv]
`default_nettype none

`include "three_stage_fall_detector_core_macros.svh"

module fdet_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire fdet_pkg::fdet_timing_t timing,
  input  wire logic                   q_empty,
  input  wire fdet_pkg::fdet_flags_t  q_head,
  output logic                        q_pop,
  output logic                        empty,
  input  wire logic                   pop,
  output logic                        fall_detected
);

  localparam int CW = fdet_pkg::CNT_W;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c == fdet_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  logic          ff_armed, im_armed, st_armed;
  logic [CW-1:0] ff_count, im_count, st_count;
  logic          ff_armed_next, im_armed_next, st_armed_next;
  logic [CW-1:0] ff_count_next, im_count_next, st_count_next;
  logic          report;
  logic          fire;

  logic                          oq [fdet_pkg::OQDEPTH];
  logic [fdet_pkg::OQPTR_W-1:0]  oq_wr;
  logic [fdet_pkg::OQPTR_W-1:0]  oq_rd;
  logic [fdet_pkg::OQCNT_W-1:0]  oq_cnt;
  logic                          oq_full;
  logic                          do_pop;

  assign oq_full = oq_cnt == fdet_pkg::OQCNT_W'(fdet_pkg::OQDEPTH);
  assign empty   = oq_cnt == '0;
  assign fire    = !q_empty && !oq_full;
  assign q_pop   = fire;
  assign do_pop  = pop && !empty;
  assign fall_detected = oq[oq_rd];

  // stage updates in the documented order
  always_comb begin
    ff_armed_next = ff_armed;
    im_armed_next = im_armed;
    st_armed_next = st_armed;
    ff_count_next = ff_count;
    im_count_next = im_count;
    st_count_next = st_count;
    report        = 1'b0;

    if (st_armed) begin
      st_count_next = sat_inc(st_count);
      if (st_count_next >= timing.settle_wait) begin
        st_armed_next = 1'b0;
        st_count_next = '0;
        report        = q_head.still_ok;
      end
    end

    if (!report) begin
      if (im_count_next >= timing.arm_window) begin
        im_armed_next = 1'b0;
        im_count_next = '0;
      end
      if (ff_count_next >= timing.arm_window) begin
        ff_armed_next = 1'b0;
        ff_count_next = '0;
      end
      if (im_armed_next) begin
        im_count_next = sat_inc(im_count_next);
        if (q_head.in_band) begin
          st_armed_next = 1'b1;
          im_armed_next = 1'b0;
          im_count_next = '0;
        end
      end
      if (ff_armed_next) begin
        ff_count_next = sat_inc(ff_count_next);
        if (q_head.am_high) begin
          im_armed_next = 1'b1;
          ff_armed_next = 1'b0;
          ff_count_next = '0;
        end
      end
      if (q_head.am_low && !im_armed_next) begin
        ff_armed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_armed <= 1'b0;
      im_armed <= 1'b0;
      st_armed <= 1'b0;
      ff_count <= '0;
      im_count <= '0;
      st_count <= '0;
    end else if (fire) begin
      ff_armed <= ff_armed_next;
      im_armed <= im_armed_next;
      st_armed <= st_armed_next;
      ff_count <= ff_count_next;
      im_count <= im_count_next;
      st_count <= st_count_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
    end else begin
      if (fire) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (do_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (fire && !do_pop) begin
        oq_cnt <= oq_cnt + 1'b1;
      end else if (do_pop && !fire) begin
        oq_cnt <= oq_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      oq[oq_wr] <= report;
    end
  end

  `FDET_ASSERT(a_oq_bound, oq_cnt <= fdet_pkg::OQCNT_W'(fdet_pkg::OQDEPTH))
  `FDET_ASSERT(a_ff_im_exclusive, !(ff_armed && im_armed))
  `FDET_ASSERT(a_ff_idle_zero, ff_armed || ff_count == '0)
  `FDET_ASSERT(a_im_idle_zero, im_armed || im_count == '0)
  `FDET_ASSERT(a_st_idle_zero, st_armed || st_count == '0)
  `FDET_ASSERT_NEXT(a_report_disarms, fire && report, !st_armed)

endmodule

`default_nettype wire

[sv/three_stage_fall_detector_core.sv]
`default_nettype none

// Three-stage fall detector: one accelerometer/gyro sample in, one fall flag out.
// Input channel: a request is offered with push and taken at a clock edge where
//   push is high and full is low; accel_* are signed Q4.12 g, gyro_* raw rates.
// Result channel: while empty is low, fall_detected holds the oldest result; it
//   is taken at an edge where pop is high and empty is low.
// Config port: cfg_we writes cfg_data into register cfg_index at once; indexes
//   0..6 are low_g_limit, high_g_limit, rotation_min, rotation_max, still_limit,
//   arm_window, settle_wait. Other indexes are ignored. Write only while idle.
// Path to the output: stage-1 registers, the classified-sample queue, the result queue.
// Throughput: one request per cycle while full is low, set by the two-stage
//   square/compare front end and the stage update of each sample in the back end.
// A four-entry queue sits between front and back, and a two-entry result queue
//   at the output, so a stalled receiver backs up through these before full rises.
// Reset (rst, synchronous): registers return to 2, 12, 30, 400, 10, 6, 10, all
//   stages disarm, counters clear, both queues empty. The squared limits follow
//   a register write in the next cycle.

module three_stage_fall_detector_core (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     push,
  output logic                                          full,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] accel_x,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] accel_y,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] accel_z,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] gyro_x,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] gyro_y,
  input  wire logic signed [fdet_pkg::SAMPLE_WIDTH-1:0] gyro_z,
  output logic                                          empty,
  input  wire logic                                     pop,
  output logic                                          fall_detected,
  input  wire logic                                     cfg_we,
  input  wire logic [fdet_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [fdet_pkg::CFG_DATA_W-1:0]          cfg_data
);

  fdet_pkg::fdet_thr_t    thr;
  fdet_pkg::fdet_timing_t timing;
  fdet_pkg::fdet_flags_t  q_in;
  fdet_pkg::fdet_flags_t  q_head;
  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_empty;

  // register file plus squared limits
  fdet_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .thr       (thr),
    .timing    (timing)
  );

  // front: squares, sums, classify against limits
  fdet_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .gyro_x  (gyro_x),
    .gyro_y  (gyro_y),
    .gyro_z  (gyro_z),
    .thr     (thr),
    .q_push  (q_push),
    .q_data  (q_in),
    .q_full  (q_full)
  );

  // decoupling queue of classified samples
  fdet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // back: arming stages, counters, result queue
  fdet_back u_back (
    .clk           (clk),
    .rst           (rst),
    .timing        (timing),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .fall_detected (fall_detected)
  );

endmodule

`default_nettype wire

[bench/three_stage_fall_detector_core_tb.sv]
module three_stage_fall_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdet_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request or result moving
  localparam int HOLD_OFF_LEN   = 80;    // long receiver hold-off, fills the queues
  localparam int DRAIN_CYCLES   = 8;     // margin after the last result, before new writes
  localparam int MAX_REPORTS    = 10;
  // index 7 decodes to nothing; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_INDEX = 3'd7;

  typedef logic signed [SAMPLE_WIDTH-1:0] raw_t;

  typedef struct {
    raw_t ax;
    raw_t ay;
    raw_t az;
    raw_t gx;
    raw_t gy;
    raw_t gz;
  } sample_t;

  // stimulus flavours: where the accel magnitude and gyro magnitude should land
  typedef enum {ACC_LOW, ACC_MID, ACC_HIGH, ACC_ANY} acc_kind_t;
  typedef enum {GYR_QUIET, GYR_BAND, GYR_STILL, GYR_ANY} gyr_kind_t;

  // Shadow of the detector: own copy of registers and stage state, plus the
  // queue of fall flags still owed by the block.
  class fall_scoreboard;
    bit [7:0]  low_g, high_g, arm_win, settle;
    bit [15:0] rot_min, rot_max, still_lim;
    bit        ff_armed, imp_armed, st_armed;
    bit [7:0]  ff_cnt, imp_cnt, st_cnt;
    bit        falls_due[$];
    int        failures;
    int        reports;

    function new();
      low_g     = LOW_G_RESET;
      high_g    = HIGH_G_RESET;
      rot_min   = ROT_MIN_RESET;
      rot_max   = ROT_MAX_RESET;
      still_lim = STILL_RESET;
      arm_win   = ARM_WIN_RESET;
      settle    = SETTLE_RESET;
      ff_armed  = 1'b0;
      imp_armed = 1'b0;
      st_armed  = 1'b0;
      ff_cnt    = '0;
      imp_cnt   = '0;
      st_cnt    = '0;
      failures  = 0;
      reports   = 0;
    endfunction

    // upper data bits beyond a register's width fall away
    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOW_G_LIMIT:  low_g     = data[7:0];
        REG_HIGH_G_LIMIT: high_g    = data[7:0];
        REG_ROTATION_MIN: rot_min   = data;
        REG_ROTATION_MAX: rot_max   = data;
        REG_STILL_LIMIT:  still_lim = data;
        REG_ARM_WINDOW:   arm_win   = data[7:0];
        REG_SETTLE_WAIT:  settle    = data[7:0];
        default: ;
      endcase
    endfunction

    static function bit [63:0] mag(raw_t v);
      if (v < 0) return 64'(-int'(v));
      return 64'(int'(v));
    endfunction

    static function bit [63:0] sum_sq(raw_t a, raw_t b, raw_t c);
      bit [63:0] ma, mb, mc;
      ma = mag(a);
      mb = mag(b);
      mc = mag(c);
      return ma * ma + mb * mb + mc * mc;
    endfunction

    static function bit [7:0] sat_inc(bit [7:0] c);
      return (c == CNT_MAX) ? c : c + 8'd1;
    endfunction

    // One sample through the stage machine; returns the fall flag.
    function bit step_detector(sample_t s);
      bit [63:0] s100, g, scale, lo1, hi;
      bit        am_low, am_high, in_band;
      s100    = 64'd100 * sum_sq(s.ax, s.ay, s.az);
      g       = sum_sq(s.gx, s.gy, s.gz);
      scale   = 64'd1 << (2 * ACCEL_FRAC_BITS);
      lo1     = 64'(low_g) + 64'd1;
      hi      = 64'(high_g);
      am_low  = s100 < lo1 * lo1 * scale;
      am_high = s100 >= hi * hi * scale;
      in_band = (g >= 64'(rot_min) * 64'(rot_min)) && (g <= 64'(rot_max) * 64'(rot_max));

      // stillness stage runs first and can end the step on its own
      if (st_armed) begin
        st_cnt = sat_inc(st_cnt);
        if (st_cnt >= settle) begin
          st_armed = 1'b0;
          st_cnt   = '0;
          if (g <= 64'(still_lim) * 64'(still_lim)) return 1'b1;
        end
      end

      // window expiry, impact before free-fall
      if (imp_cnt >= arm_win) begin
        imp_armed = 1'b0;
        imp_cnt   = '0;
      end
      if (ff_cnt >= arm_win) begin
        ff_armed = 1'b0;
        ff_cnt   = '0;
      end

      if (imp_armed) begin
        imp_cnt = sat_inc(imp_cnt);
        if (in_band) begin
          st_armed  = 1'b1;
          imp_armed = 1'b0;
          imp_cnt   = '0;
        end
      end

      if (ff_armed) begin
        ff_cnt = sat_inc(ff_cnt);
        if (am_high) begin
          imp_armed = 1'b1;
          ff_armed  = 1'b0;
          ff_cnt    = '0;
        end
      end

      if (am_low && !imp_armed) ff_armed = 1'b1;
      return 1'b0;
    endfunction

    function void note_request(sample_t s);
      falls_due.push_back(step_detector(s));
    endfunction

    function void check_result(logic actual);
      bit want;
      if (falls_due.size() == 0) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("[%0t] result with nothing due: fall_detected=%b", $realtime, actual);
        end
        return;
      end
      want = falls_due.pop_front();
      if (actual !== want) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("[%0t] fall_detected mismatch: expected %b, actual %b",
                   $realtime, want, actual);
        end
      end
    endfunction

    function int pending();
      return falls_due.size();
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  push      = 1'b0;
  logic                  full;
  raw_t                  accel_x   = '0;
  raw_t                  accel_y   = '0;
  raw_t                  accel_z   = '0;
  raw_t                  gyro_x    = '0;
  raw_t                  gyro_y    = '0;
  raw_t                  gyro_z    = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic                  fall_detected;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  fall_scoreboard sb;

  int burst_left   = 0;   // requests left in the current sender burst
  int stall_left   = 0;   // receiver short stall
  int free_left    = 0;   // receiver run with no stalls
  int hold_left    = 0;   // receiver long hold-off
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;
  int idle_cycles  = 0;
  int sent_count   = 0;   // requests accepted so far

  always #(CLK_PERIOD / 2) clk = ~clk;

  three_stage_fall_detector_core DUT (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .accel_x       (accel_x),
    .accel_y       (accel_y),
    .accel_z       (accel_z),
    .gyro_x        (gyro_x),
    .gyro_y        (gyro_y),
    .gyro_z        (gyro_z),
    .empty         (empty),
    .pop           (pop),
    .fall_detected (fall_detected),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Sample construction
  // ---------------------------------------------------------------------

  function automatic sample_t pack_sample(int ax, int ay, int az, int gx, int gy, int gz);
    sample_t s;
    s.ax = raw_t'(ax);
    s.ay = raw_t'(ay);
    s.az = raw_t'(az);
    s.gx = raw_t'(gx);
    s.gy = raw_t'(gy);
    s.gz = raw_t'(gz);
    return s;
  endfunction

  // magnitude m with a random sign; 32768 only exists as the negative code
  function automatic raw_t with_sign(int m);
    if (m >= 32768) return raw_t'(-32768);
    if ($urandom_range(0, 1) == 1) return raw_t'(-m);
    return raw_t'(m);
  endfunction

  // uniform in [-bound, bound]
  function automatic raw_t spread(int bound);
    return raw_t'(int'($urandom_range(0, 2 * bound)) - bound);
  endfunction

  // Aims the sample at a stage condition under the live register values.
  // Only a bias: the scoreboard decides what actually happens.
  function automatic sample_t make_sample(acc_kind_t ak, gyr_kind_t gk);
    sample_t s;
    raw_t    a[3];
    raw_t    w[3];
    int      bound;
    int      m;
    int      top;
    int      axis;
    foreach (a[i]) a[i] = '0;
    foreach (w[i]) w[i] = '0;
    axis = $urandom_range(0, 2);

    case (ak)
      ACC_LOW: begin
        // keep |a| under (low_g+1)/10 g, with margin for three axes
        bound = ((int'(sb.low_g) + 1) * 4096) / 20;
        if (bound > 32767) bound = 32767;
        foreach (a[i]) a[i] = spread(bound);
      end
      ACC_MID: begin
        foreach (a[i]) a[i] = spread(300);
        a[axis] = with_sign(3696 + int'($urandom_range(0, 800)));
      end
      ACC_HIGH: begin
        foreach (a[i]) a[i] = spread(1000);
        m = int'(sb.high_g) * 410 + int'($urandom_range(0, 2000));
        a[axis] = with_sign((m > 32767) ? 32767 : m);
      end
      default: foreach (a[i]) a[i] = raw_t'($urandom());
    endcase

    case (gk)
      GYR_BAND: begin
        if (sb.rot_min <= sb.rot_max) begin
          top = (sb.rot_max > 32768) ? 32768 : int'(sb.rot_max);
          if (int'(sb.rot_min) > top) m = top;
          else m = $urandom_range(sb.rot_min, top);
          w[axis] = with_sign(m);
        end else begin
          foreach (w[i]) w[i] = raw_t'($urandom());
        end
      end
      GYR_STILL: begin
        top = (sb.still_lim > 32768) ? 32768 : int'(sb.still_lim);
        w[axis] = with_sign($urandom_range(0, top));
      end
      GYR_QUIET: foreach (w[i]) w[i] = spread(5);
      default: foreach (w[i]) w[i] = raw_t'($urandom());
    endcase

    s.ax = a[0];
    s.ay = a[1];
    s.az = a[2];
    s.gx = w[0];
    s.gy = w[1];
    s.gz = w[2];
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // Driving tasks
  // ---------------------------------------------------------------------

  // Offer one request and hold it until taken. Bursts of random length with
  // random gaps; here push is only lowered at the start of a gap.
  task automatic send(sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push    <= 1'b1;
    accel_x <= s.ax;
    accel_y <= s.ay;
    accel_z <= s.az;
    gyro_x  <= s.gx;
    gyro_y  <= s.gy;
    gyro_z  <= s.gz;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(s);
    sent_count++;
    burst_left--;
  endtask

  // cfg_we stays high across back-to-back writes; end_writes drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic write_all(int lg, int hg, int rmin, int rmax, int still, int arm, int settle);
    write_reg(REG_LOW_G_LIMIT,  CFG_DATA_W'(lg));
    write_reg(REG_HIGH_G_LIMIT, CFG_DATA_W'(hg));
    write_reg(REG_ROTATION_MIN, CFG_DATA_W'(rmin));
    write_reg(REG_ROTATION_MAX, CFG_DATA_W'(rmax));
    write_reg(REG_STILL_LIMIT,  CFG_DATA_W'(still));
    write_reg(REG_ARM_WINDOW,   CFG_DATA_W'(arm));
    write_reg(REG_SETTLE_WAIT,  CFG_DATA_W'(settle));
  endtask

  // squared limits follow a write in the next cycle; give them room
  task automatic end_writes();
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // every request yields one result, so an empty scoreboard means idle
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Free-fall, impact, rotation, settle, stillness: the path to a fall,
  // with random content and sometimes a lead long enough to time out.
  task automatic send_fall_attempt();
    int lead;
    int settle_fill;
    lead = 0;
    if (sb.arm_win > 4) lead = $urandom_range(0, 3);
    else if (sb.arm_win > 1) lead = $urandom_range(0, sb.arm_win - 1);
    if ($urandom_range(0, 7) == 0 && sb.arm_win <= 8) lead = sb.arm_win;
    settle_fill = int'(sb.settle) - 1;
    if (settle_fill < 0) settle_fill = 0;

    send(make_sample(ACC_LOW, GYR_QUIET));
    repeat (lead) send(make_sample(ACC_MID, GYR_ANY));
    send(make_sample(ACC_HIGH, GYR_QUIET));
    repeat (lead) send(make_sample(ACC_MID, GYR_QUIET));
    send(make_sample(ACC_MID, GYR_BAND));
    repeat (settle_fill) send(make_sample(ACC_MID, GYR_ANY));
    if ($urandom_range(0, 3) != 0) send(make_sample(ACC_MID, GYR_STILL));
    else send(make_sample(ACC_ANY, GYR_ANY));
  endtask

  // about n requests, mostly fall attempts, a quarter pure noise; attempts
  // whose settle wait alone outruns the phase are replaced by noise
  task automatic run_phase(int n);
    int start;
    start = sent_count;
    while (sent_count - start < n) begin
      if ($urandom_range(0, 3) != 0 && int'(sb.settle) < n) begin
        send_fall_attempt();
      end else begin
        send(make_sample(ACC_ANY, GYR_ANY));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: short random stalls, free runs, and one long hold-off that is
  // asked for by the stimulus and counted here.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(fall_detected);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (free_left > 0) begin
        free_left--;
        pop <= 1'b1;
      end else begin
        case ($urandom_range(0, 7))
          0, 1: begin
            stall_left = $urandom_range(0, 5);
            pop <= 1'b0;
          end
          2: begin
            free_left = $urandom_range(20, 60);
            pop <= 1'b1;
          end
          default: pop <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog: too long with neither a request nor a result moving.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int lg, hg, rmin, rmax, still, arm, settle;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset register values. A clean fall first: dip, impact,
    // rotation in band, nine settle samples, then a near-still gyro.
    send(pack_sample(0, 0, 100, 0, 0, 0));
    send(pack_sample(0, 0, 4920, 0, 0, 0));
    send(pack_sample(0, 0, 4096, 200, 0, 0));
    repeat (9) send(pack_sample(0, 0, 4096, 0, 0, 0));
    send(pack_sample(0, 0, 4096, 7, 0, 0));
    // field extremes
    send(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send(pack_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send(pack_sample(0, 0, 0, 0, 0, 0));
    send(pack_sample(32767, 32767, 32767, -32768, -32768, -32768));
    send(pack_sample(1, -1, 1, -1, 1, -1));
    send(pack_sample(-32768, 0, 32767, 0, -32768, 32767));

    // Junk in the upper bits of the 8-bit registers, and a write to an
    // index that decodes to nothing.
    wait_idle();
    write_all('hFF03, 'h5A0A, 50, 2000, 40, 'hC304, 'h7703);
    write_reg(UNUSED_REG_INDEX, CFG_DATA_W'($urandom()));
    end_writes();
    run_phase(50);

    // zero arm window and zero settle wait
    wait_idle();
    write_all(2, 12, 30, 400, 10, 0, 0);
    end_writes();
    run_phase(35);

    // every register at its top
    wait_idle();
    write_all(255, 255, 65535, 65535, 65535, 255, 255);
    end_writes();
    run_phase(20);

    // every register at its bottom (windows at one)
    wait_idle();
    write_all(0, 0, 0, 0, 0, 1, 1);
    end_writes();
    run_phase(30);

    // inverted rotation band: stillness can never arm
    wait_idle();
    write_all(2, 12, 500, 100, 10, 6, 10);
    end_writes();
    run_phase(25);

    // Longest settle wait, one full attempt through it. The receiver holds
    // off meanwhile so the queues fill and full pushes back.
    wait_idle();
    write_all(3, 11, 20, 3000, 100, 255, 255);
    end_writes();
    hold_request = 1'b1;
    send_fall_attempt();
    run_phase(10);

    // random settings in a range where falls are reachable
    repeat (3) begin
      wait_idle();
      lg     = $urandom_range(0, 8);
      hg     = $urandom_range(6, 30);
      rmin   = $urandom_range(0, 500);
      rmax   = rmin + int'($urandom_range(0, 5000));
      still  = $urandom_range(0, 200);
      arm    = $urandom_range(1, 8);
      settle = $urandom_range(1, 12);
      write_all(lg, hg, rmin, rmax, still, arm, settle);
      end_writes();
      run_phase(30);
    end

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/fdet_pkg.sv
sv/fdet_cfg.sv
sv/fdet_front.sv
sv/fdet_queue.sv
sv/fdet_back.sv
sv/three_stage_fall_detector_core.sv
bench/three_stage_fall_detector_core_tb.sv
